[hw/rtl/crct_pkg.sv]
`timescale 1ns / 1ps
// Shared widths, constants, step tables and control structs of the curve tessellator.
package crct_pkg;

  // Coordinate and sample formats
  localparam int COORD_BITS  = 24;
  localparam int MAX_STEPS   = 31;
  localparam int STEPS_W     = 5;
  localparam int SAMPLE_BITS = 26;
  localparam int T_FRAC      = 16;
  localparam int T_W         = T_FRAC + 1;

  // Reflected points, coefficients, Horner accumulator and product widths
  localparam int QW = COORD_BITS + 2;
  localparam int CW = COORD_BITS + 6;
  localparam int AW = COORD_BITS + 7;
  localparam int PW = AW + T_W + 1;

  // Horner pipeline depth ahead of the output register
  localparam int PIPE_STAGES = 6;

  localparam logic [STEPS_W-1:0] STEPS_RESET = STEPS_W'(4);

  // Controller to datapath commands
  typedef struct packed {
    logic latch_item;
    logic load_quad;
    logic load_coef;
    logic issue;
    logic seg_b;
    logic front_refl;
    logic seg_start;
    logic last_run;
    logic win_shift;
    logic win_clear;
  } ctl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [STEPS_W-1:0] steps;
    logic               adv;
  } dp_status_t;

  // Tag that travels with each sample through the pipeline
  typedef struct packed {
    logic valid;
    logic start;
    logic last;
  } smp_tag_t;

  // Quotient of 2^T_FRAC by the step count
  function automatic logic [T_W-1:0] step_quot(input logic [STEPS_W-1:0] steps);
    logic [T_W-1:0] q;
    case (steps)
      5'd1:    q = T_W'(65536);
      5'd2:    q = T_W'(32768);
      5'd3:    q = T_W'(21845);
      5'd4:    q = T_W'(16384);
      5'd5:    q = T_W'(13107);
      5'd6:    q = T_W'(10922);
      5'd7:    q = T_W'(9362);
      5'd8:    q = T_W'(8192);
      5'd9:    q = T_W'(7281);
      5'd10:   q = T_W'(6553);
      5'd11:   q = T_W'(5957);
      5'd12:   q = T_W'(5461);
      5'd13:   q = T_W'(5041);
      5'd14:   q = T_W'(4681);
      5'd15:   q = T_W'(4369);
      5'd16:   q = T_W'(4096);
      5'd17:   q = T_W'(3855);
      5'd18:   q = T_W'(3640);
      5'd19:   q = T_W'(3449);
      5'd20:   q = T_W'(3276);
      5'd21:   q = T_W'(3120);
      5'd22:   q = T_W'(2978);
      5'd23:   q = T_W'(2849);
      5'd24:   q = T_W'(2730);
      5'd25:   q = T_W'(2621);
      5'd26:   q = T_W'(2520);
      5'd27:   q = T_W'(2427);
      5'd28:   q = T_W'(2340);
      5'd29:   q = T_W'(2259);
      5'd30:   q = T_W'(2184);
      5'd31:   q = T_W'(2114);
      default: q = T_W'(65536);
    endcase
    return q;
  endfunction

  // Remainder of 2^T_FRAC by the step count
  function automatic logic [STEPS_W-1:0] step_rem(input logic [STEPS_W-1:0] steps);
    logic [STEPS_W-1:0] r;
    case (steps)
      5'd3, 5'd5, 5'd15, 5'd17:            r = STEPS_W'(1);
      5'd7, 5'd14, 5'd31:                  r = STEPS_W'(2);
      5'd13:                               r = STEPS_W'(3);
      5'd6, 5'd12:                         r = STEPS_W'(4);
      5'd19:                               r = STEPS_W'(5);
      5'd10:                               r = STEPS_W'(6);
      5'd9, 5'd27:                         r = STEPS_W'(7);
      5'd11, 5'd23:                        r = STEPS_W'(9);
      5'd25:                               r = STEPS_W'(11);
      5'd18, 5'd20, 5'd21, 5'd24, 5'd26,
      5'd28, 5'd30:                        r = STEPS_W'(16);
      5'd22:                               r = STEPS_W'(20);
      5'd29:                               r = STEPS_W'(25);
      default:                             r = '0;
    endcase
    return r;
  endfunction

endpackage

[hw/rtl/crct_point_if.sv]
`timescale 1ns / 1ps
// Control point channel: valid/ready handshake with one 3D point and the chain end flag.
interface crct_point_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [crct_pkg::COORD_BITS-1:0]     point_x;
  logic signed [crct_pkg::COORD_BITS-1:0]     point_y;
  logic signed [crct_pkg::COORD_BITS-1:0]     point_z;
  logic                                       chain_end;

  modport source (output valid, point_x, point_y, point_z, chain_end, input ready);
  modport sink   (input valid, point_x, point_y, point_z, chain_end, output ready);
endinterface

[hw/rtl/crct_sample_if.sv]
`timescale 1ns / 1ps
// Curve sample channel: valid/ready handshake with one sample and its flags.
interface crct_sample_if;
  logic                                       valid;
  logic                                       ready;
  logic signed [crct_pkg::SAMPLE_BITS-1:0]    sample_x;
  logic signed [crct_pkg::SAMPLE_BITS-1:0]    sample_y;
  logic signed [crct_pkg::SAMPLE_BITS-1:0]    sample_z;
  logic                                       segment_start;
  logic                                       last_of_run;

  modport source (output valid, sample_x, sample_y, sample_z, segment_start, last_of_run,
                  input ready);
  modport sink   (input valid, sample_x, sample_y, sample_z, segment_start, last_of_run,
                  output ready);
endinterface

[hw/rtl/crct_axis.sv]
`timescale 1ns / 1ps
// One axis: segment point selection, cubic coefficients and pipelined Horner evaluation.
module crct_axis (
  input  logic                                    clk_i,
  input  crct_pkg::ctl_cmd_t                      cmd_i,
  input  logic                                    adv_i,
  input  logic        [crct_pkg::T_W-1:0]         t_i,
  input  logic signed [crct_pkg::COORD_BITS-1:0]  w0_i,
  input  logic signed [crct_pkg::COORD_BITS-1:0]  w1_i,
  input  logic signed [crct_pkg::COORD_BITS-1:0]  w2_i,
  input  logic signed [crct_pkg::COORD_BITS-1:0]  p_i,
  output logic signed [crct_pkg::SAMPLE_BITS-1:0] sample_o
);

  localparam int QW = crct_pkg::QW;
  localparam int CW = crct_pkg::CW;
  localparam int AW = crct_pkg::AW;
  localparam int PW = crct_pkg::PW;
  localparam int SB = crct_pkg::SAMPLE_BITS;
  localparam int T_W_S = crct_pkg::T_W + 1;
  localparam logic signed [AW-1:0] SAT_HI = AW'((2 ** (SB - 1)) - 1);
  localparam logic signed [AW-1:0] SAT_LO = -SAT_HI - AW'(1);
  localparam logic signed [PW-1:0] T_HALF = PW'(2 ** (crct_pkg::T_FRAC - 1));

  // Round a product to nearest at the binary point, ties up
  function automatic logic signed [AW-1:0] rnd_t(input logic signed [PW-1:0] v);
    logic signed [PW-1:0] sum;
    logic signed [PW-1:0] shr;
    sum = v + T_HALF;
    shr = sum >>> crct_pkg::T_FRAC;
    return shr[AW-1:0];
  endfunction

  logic signed [QW-1:0] q0_d, q1_d, q2_d, q3_d;
  logic signed [QW-1:0] q0_q, q1_q, q2_q, q3_q;
  logic signed [CW-1:0] e0, e1, e2, e3;
  logic signed [CW-1:0] a3_q, a2_q, a1_q, a0_q;
  logic signed [T_W_S-1:0] t_s;

  logic signed [PW-1:0] prod1_q, prod2_q, prod3_q;
  logic signed [AW-1:0] acc1_q, acc2_q, acc3_q;
  logic signed [T_W_S-1:0] t1_q, t2_q, t3_q, t4_q;
  logic signed [CW-1:0] c2_1_q, c1_1_q, c0_1_q;
  logic signed [CW-1:0] c1_2_q, c0_2_q;
  logic signed [CW-1:0] c1_3_q, c0_3_q;
  logic signed [CW-1:0] c0_4_q, c0_5_q;
  logic signed [AW-1:0] half_v;
  logic signed [SB-1:0] sat_v;

  // Select the four segment points, reflecting missing end neighbors
  always_comb begin
    q1_d = cmd_i.seg_b ? QW'(w2_i) : QW'(w1_i);
    q2_d = cmd_i.seg_b ? QW'(p_i) : QW'(w2_i);
    if (cmd_i.front_refl) begin
      q0_d = (q1_d <<< 1) - q2_d;
    end else begin
      q0_d = cmd_i.seg_b ? QW'(w1_i) : QW'(w0_i);
    end
    q3_d = cmd_i.seg_b ? ((q2_d <<< 1) - q1_d) : QW'(p_i);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_quad) begin
      q0_q <= q0_d;
      q1_q <= q1_d;
      q2_q <= q2_d;
      q3_q <= q3_d;
    end
  end

  // Build the cubic coefficients of the held segment
  assign e0 = CW'(q0_q);
  assign e1 = CW'(q1_q);
  assign e2 = CW'(q2_q);
  assign e3 = CW'(q3_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_coef) begin
      a3_q <= (e1 <<< 1) + e1 - e0 - (e2 <<< 1) - e2 + e3;
      a2_q <= (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
      a1_q <= e2 - e0;
      a0_q <= e1 <<< 1;
    end
  end

  assign t_s = $signed({1'b0, t_i});

  // Advance the Horner stages, carrying the later coefficients along
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      prod1_q <= a3_q * t_s;
      t1_q    <= t_s;
      c2_1_q  <= a2_q;
      c1_1_q  <= a1_q;
      c0_1_q  <= a0_q;

      acc1_q  <= AW'(c2_1_q) + rnd_t(prod1_q);
      t2_q    <= t1_q;
      c1_2_q  <= c1_1_q;
      c0_2_q  <= c0_1_q;

      prod2_q <= acc1_q * t2_q;
      t3_q    <= t2_q;
      c1_3_q  <= c1_2_q;
      c0_3_q  <= c0_2_q;

      acc2_q  <= AW'(c1_3_q) + rnd_t(prod2_q);
      t4_q    <= t3_q;
      c0_4_q  <= c0_3_q;

      prod3_q <= acc2_q * t4_q;
      c0_5_q  <= c0_4_q;

      acc3_q  <= AW'(c0_5_q) + rnd_t(prod3_q);

      sample_o <= sat_v;
    end
  end

  // Halve with rounding and saturate to the sample width
  always_comb begin
    half_v = (acc3_q + AW'(1)) >>> 1;
    if (half_v > SAT_HI) begin
      sat_v = SAT_HI[SB-1:0];
    end else if (half_v < SAT_LO) begin
      sat_v = SAT_LO[SB-1:0];
    end else begin
      sat_v = half_v[SB-1:0];
    end
  end

endmodule

[hw/rtl/crct_datapath.sv]
`timescale 1ns / 1ps
// Datapath: step register, point window, parameter stepper, axis units and output register.
module crct_datapath (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic        [crct_pkg::STEPS_W-1:0]     cfg_wdata_i,
  input  logic signed [crct_pkg::COORD_BITS-1:0]  in_x_i,
  input  logic signed [crct_pkg::COORD_BITS-1:0]  in_y_i,
  input  logic signed [crct_pkg::COORD_BITS-1:0]  in_z_i,
  input  crct_pkg::ctl_cmd_t                      cmd_i,
  output crct_pkg::dp_status_t                    status_o,
  crct_sample_if.source                           sample_o
);

  localparam int CB = crct_pkg::COORD_BITS;
  localparam int SW = crct_pkg::STEPS_W;
  localparam int TW = crct_pkg::T_W;
  localparam int NS = crct_pkg::PIPE_STAGES;

  logic [SW-1:0]        steps_q;
  logic [SW-1:0]        steps_eff;
  logic signed [CB-1:0] p_q   [3];
  logic signed [CB-1:0] win_q [3][3];
  logic [TW-1:0]        t_q;
  logic [SW-1:0]        r_q;
  logic [SW:0]          r_sum;
  logic [TW-1:0]        quot;
  logic [SW-1:0]        rem;
  logic                 adv;
  crct_pkg::smp_tag_t   tag_q [NS];
  crct_pkg::smp_tag_t   out_tag_q;
  crct_pkg::smp_tag_t   tag_in;
  logic signed [crct_pkg::SAMPLE_BITS-1:0] smp [3];

  // Hold the step count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      steps_q <= crct_pkg::STEPS_RESET;
    end else if (cfg_we_i) begin
      steps_q <= cfg_wdata_i;
    end
  end

  // Clamp the step count into its legal range
  always_comb begin
    if (steps_q == '0) begin
      steps_eff = SW'(1);
    end else if (steps_q > SW'(crct_pkg::MAX_STEPS)) begin
      steps_eff = SW'(crct_pkg::MAX_STEPS);
    end else begin
      steps_eff = steps_q;
    end
  end

  assign quot = crct_pkg::step_quot(steps_eff);
  assign rem  = crct_pkg::step_rem(steps_eff);

  // Latch the incoming point
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_item) begin
      p_q[0] <= in_x_i;
      p_q[1] <= in_y_i;
      p_q[2] <= in_z_i;
    end
  end

  // Shift the point into the window, or drop the window at chain end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 3; k++) begin
          win_q[a][k] <= '0;
        end
      end
    end else if (cmd_i.win_clear) begin
      for (int a = 0; a < 3; a++) begin
        for (int k = 0; k < 3; k++) begin
          win_q[a][k] <= '0;
        end
      end
    end else if (cmd_i.win_shift) begin
      for (int a = 0; a < 3; a++) begin
        win_q[a][0] <= win_q[a][1];
        win_q[a][1] <= win_q[a][2];
        win_q[a][2] <= p_q[a];
      end
    end
  end

  // Step t = round(s * 2^16 / steps) by quotient and remainder
  assign r_sum = {1'b0, r_q} + {1'b0, rem};

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_coef) begin
      t_q <= '0;
      r_q <= steps_eff >> 1;
    end else if (cmd_i.issue) begin
      if (r_sum >= {1'b0, steps_eff}) begin
        r_q <= SW'(r_sum - {1'b0, steps_eff});
        t_q <= t_q + quot + TW'(1);
      end else begin
        r_q <= r_sum[SW-1:0];
        t_q <= t_q + quot;
      end
    end
  end

  // Move the pipeline whenever the output register is free or being taken
  assign adv = !out_tag_q.valid || sample_o.ready;

  assign tag_in.valid = cmd_i.issue;
  assign tag_in.start = cmd_i.seg_start;
  assign tag_in.last  = cmd_i.last_run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NS; k++) begin
        tag_q[k] <= '0;
      end
      out_tag_q <= '0;
    end else if (adv) begin
      tag_q[0] <= tag_in;
      for (int k = 1; k < NS; k++) begin
        tag_q[k] <= tag_q[k-1];
      end
      out_tag_q <= tag_q[NS-1];
    end
  end

  // Evaluate all three axes side by side
  for (genvar a = 0; a < 3; a++) begin : g_axis
    crct_axis u_axis (
      .clk_i    (clk_i),
      .cmd_i    (cmd_i),
      .adv_i    (adv),
      .t_i      (t_q),
      .w0_i     (win_q[a][0]),
      .w1_i     (win_q[a][1]),
      .w2_i     (win_q[a][2]),
      .p_i      (p_q[a]),
      .sample_o (smp[a])
    );
  end

  assign sample_o.valid         = out_tag_q.valid;
  assign sample_o.sample_x      = smp[0];
  assign sample_o.sample_y      = smp[1];
  assign sample_o.sample_z      = smp[2];
  assign sample_o.segment_start = out_tag_q.start;
  assign sample_o.last_of_run   = out_tag_q.last;

  assign status_o.steps = steps_eff;
  assign status_o.adv   = adv;

endmodule

[hw/rtl/crct_ctrl.sv]
`timescale 1ns / 1ps
// Controller: plans the segments of each point and sequences loading and sample issue.
module crct_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_end_i,
  input  crct_pkg::dp_status_t  status_i,
  output logic                  in_ready_o,
  output crct_pkg::ctl_cmd_t    cmd_o
);

  localparam int SW = crct_pkg::STEPS_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_COEF   = 3'd2;
  localparam logic [2:0] ST_ISSUE  = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  logic [2:0]    state_q, state_d;
  logic [1:0]    seen_q, seen_d;
  logic          end_q, end_d;
  logic          has_b_q, has_b_d;
  logic          seg_b_q, seg_b_d;
  logic          refl_q, refl_d;
  logic [SW-1:0] s_q, s_d;
  logic          accept;
  logic          last_s;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_ready_o && in_valid_i;
  assign last_s     = seg_b_q ? (s_q == status_i.steps) : (s_q == status_i.steps - SW'(1));

  // Sequence one point: plan, load points, build coefficients, issue, retire
  always_comb begin
    state_d = state_q;
    seen_d  = seen_q;
    end_d   = end_q;
    has_b_d = has_b_q;
    seg_b_d = seg_b_q;
    refl_d  = refl_q;
    s_d     = s_q;
    cmd_o   = '0;
    cmd_o.seg_b      = seg_b_q;
    cmd_o.front_refl = refl_q;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_o.latch_item = 1'b1;
          end_d   = in_end_i;
          has_b_d = in_end_i && (seen_q != 2'd0);
          if (seen_q >= 2'd2) begin
            seg_b_d = 1'b0;
            refl_d  = (seen_q == 2'd2);
            state_d = ST_LOAD;
          end else if (in_end_i && (seen_q == 2'd1)) begin
            seg_b_d = 1'b1;
            refl_d  = 1'b1;
            state_d = ST_LOAD;
          end else begin
            state_d = ST_FINISH;
          end
        end
      end
      ST_LOAD: begin
        cmd_o.load_quad = 1'b1;
        state_d = ST_COEF;
      end
      ST_COEF: begin
        cmd_o.load_coef = 1'b1;
        s_d     = '0;
        state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (status_i.adv) begin
          cmd_o.issue     = 1'b1;
          cmd_o.seg_start = (s_q == '0);
          cmd_o.last_run  = last_s && (seg_b_q || !has_b_q);
          s_d = s_q + SW'(1);
          if (last_s) begin
            if (!seg_b_q && has_b_q) begin
              seg_b_d = 1'b1;
              refl_d  = (seen_q == 2'd1);
              state_d = ST_LOAD;
            end else begin
              state_d = ST_FINISH;
            end
          end
        end
      end
      ST_FINISH: begin
        cmd_o.win_clear = end_q;
        cmd_o.win_shift = !end_q;
        if (end_q) begin
          seen_d = '0;
        end else if (seen_q != 2'd3) begin
          seen_d = seen_q + 2'd1;
        end
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      seen_q  <= '0;
      end_q   <= 1'b0;
      has_b_q <= 1'b0;
      seg_b_q <= 1'b0;
      refl_q  <= 1'b0;
      s_q     <= '0;
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
      end_q   <= end_d;
      has_b_q <= has_b_d;
      seg_b_q <= seg_b_d;
      refl_q  <= refl_d;
      s_q     <= s_d;
    end
  end

endmodule

[hw/rtl/catmull_rom_curve_tessellator_unit.sv]
`timescale 1ns / 1ps
// Top level of the uniform Catmull-Rom curve tessellator.
//
//   channel    direction  handshake          word
//   point_i    in         valid / ready      point_x/y/z (Q15.8), chain_end
//   sample_o   out        valid / ready      sample_x/y/z (Q17.8), segment_start, last_of_run
//   cfg        in         cfg_we_i           steps_per_segment (5 bits)
//
// A point is taken only while the controller is idle. A point that closes no segment
// issues no samples; one that closes a segment issues its samples, and a chain end point
// may close two segments. Samples leave at one per cycle while the output is not stalled,
// behind a registered Horner pipeline (three multipliers per axis). A stalled output freezes
// the pipeline and sample issue. Reset clears the window, the point count and steps to 4.
module catmull_rom_curve_tessellator_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [crct_pkg::STEPS_W-1:0]         cfg_wdata_i,
  crct_point_if.sink                           point_i,
  crct_sample_if.source                        sample_o
);

  crct_pkg::ctl_cmd_t   cmd;
  crct_pkg::dp_status_t status;
  logic                 in_ready;

  assign point_i.ready = in_ready;

  // Sequence each point
  crct_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (point_i.valid),
    .in_end_i   (point_i.chain_end),
    .status_i   (status),
    .in_ready_o (in_ready),
    .cmd_o      (cmd)
  );

  // Evaluate the segments
  crct_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_x_i      (point_i.point_x),
    .in_y_i      (point_i.point_y),
    .in_z_i      (point_i.point_z),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_o    (sample_o)
  );

endmodule
